// File: rtl/core/lcdseq_pkg.sv
// Shared types, codes and constants of the character LCD nibble write sequencer.
package lcdseq_pkg;

  // Operation codes carried in the cmd field of a request.
  localparam logic [1:0] OP_WRITE_CMD  = 2'd0;
  localparam logic [1:0] OP_WRITE_CHAR = 2'd1;
  localparam logic [1:0] OP_SET_CURSOR = 2'd2;
  localparam logic [1:0] OP_POWER_UP   = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_ENABLE_PULSE   = 2'd0;
  localparam logic [1:0] REG_COMMAND_SETTLE = 2'd1;
  localparam logic [1:0] REG_DATA_SETTLE    = 2'd2;
  localparam logic [1:0] REG_INIT_SETTLE    = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [15:0] RST_ENABLE_PULSE   = 16'd1000;
  localparam logic [15:0] RST_COMMAND_SETTLE = 16'd1000;
  localparam logic [15:0] RST_DATA_SETTLE    = 16'd100;
  localparam logic [15:0] RST_INIT_SETTLE    = 16'd2000;

  // Cursor address bases for the two display lines.
  localparam logic [7:0] ROW0_BASE = 8'h80;
  localparam logic [7:0] ROW1_BASE = 8'hC0;

  // Last bus-state phase of a byte and last byte index of the power-up sequence.
  localparam logic [2:0] PHASE_LAST     = 3'd5;
  localparam logic [2:0] INIT_LAST_BYTE = 3'd6;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] byte_value;
    logic       row;
    logic [5:0] column;
  } in_item_t;

  typedef struct packed {
    logic        register_select;
    logic        read_write;
    logic        enable_pin;
    logic [3:0]  data_nibble;
    logic [15:0] hold_us;
    logic        last;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic       load;
    logic       emit;
    logic [2:0] phase;
    logic [2:0] byte_idx;
    logic       last_byte;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_init;
  } dp_status_t;

  // Power-up command sequence.
  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h33;
      3'd1:    b = 8'h32;
      3'd2:    b = 8'h28;
      3'd3:    b = 8'h01;
      3'd4:    b = 8'h02;
      3'd5:    b = 8'h06;
      3'd6:    b = 8'h0C;
      default: b = 8'h0C;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/core/lcdseq_ctrl.sv
// Controller state machine that steps through bytes and bus-state phases.
module lcdseq_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  lcdseq_pkg::dp_status_t status,
  output lcdseq_pkg::ctrl_cmd_t  ctrl
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic       state_r, state_nxt;
  logic [2:0] phase_r, phase_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       last_byte;
  logic       final_step;
  logic       accept;

  assign last_byte  = !status.is_init || (idx_r == lcdseq_pkg::INIT_LAST_BYTE);
  assign final_step = (state_r == ST_RUN) && (phase_r == lcdseq_pkg::PHASE_LAST) && last_byte;
  // The next request may be taken in the cycle that emits the final bus state.
  assign busy       = (state_r == ST_RUN) && !final_step;
  assign accept     = start && !busy;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RUN;
          phase_nxt = 3'd0;
          idx_nxt   = 3'd0;
        end
      end
      ST_RUN: begin
        if (final_step) begin
          if (accept) begin
            phase_nxt = 3'd0;
            idx_nxt   = 3'd0;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else if (phase_r == lcdseq_pkg::PHASE_LAST) begin
          phase_nxt = 3'd0;
          idx_nxt   = idx_r + 3'd1;
        end else begin
          phase_nxt = phase_r + 3'd1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= 3'd0;
      idx_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign ctrl.load      = accept;
  assign ctrl.emit      = (state_r == ST_RUN);
  assign ctrl.phase     = phase_r;
  assign ctrl.byte_idx  = idx_r;
  assign ctrl.last_byte = last_byte;

endmodule

// File: rtl/core/lcdseq_dp.sv
// Datapath: configuration registers, request latch and registered bus-state output.
module lcdseq_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  input  lcdseq_pkg::in_item_t  in_req,
  input  lcdseq_pkg::ctrl_cmd_t ctrl,
  output lcdseq_pkg::dp_status_t status,
  output logic                  out_valid,
  output lcdseq_pkg::out_item_t out_res
);

  logic [15:0] enable_pulse_r, command_settle_r, data_settle_r, init_settle_r;
  logic [7:0]  byte_r, byte_nxt;
  logic        rs_r, rs_nxt;
  logic        init_r;
  logic        out_valid_r;
  lcdseq_pkg::out_item_t out_r, out_nxt;

  logic [16:0] init_sum;
  logic [15:0] init_hold;
  logic [7:0]  cur_byte;
  logic [15:0] settle;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_pulse_r   <= lcdseq_pkg::RST_ENABLE_PULSE;
      command_settle_r <= lcdseq_pkg::RST_COMMAND_SETTLE;
      data_settle_r    <= lcdseq_pkg::RST_DATA_SETTLE;
      init_settle_r    <= lcdseq_pkg::RST_INIT_SETTLE;
    end else if (cfg_valid) begin
      case (cfg_index)
        lcdseq_pkg::REG_ENABLE_PULSE:   enable_pulse_r   <= cfg_data;
        lcdseq_pkg::REG_COMMAND_SETTLE: command_settle_r <= cfg_data;
        lcdseq_pkg::REG_DATA_SETTLE:    data_settle_r    <= cfg_data;
        lcdseq_pkg::REG_INIT_SETTLE:    init_settle_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    byte_nxt = in_req.byte_value;
    rs_nxt   = 1'b0;
    case (in_req.cmd)
      lcdseq_pkg::OP_WRITE_CMD:  byte_nxt = in_req.byte_value;
      lcdseq_pkg::OP_WRITE_CHAR: begin
        byte_nxt = in_req.byte_value;
        rs_nxt   = 1'b1;
      end
      lcdseq_pkg::OP_SET_CURSOR: begin
        byte_nxt = (in_req.row ? lcdseq_pkg::ROW1_BASE : lcdseq_pkg::ROW0_BASE)
                   + {2'b00, in_req.column};
      end
      default: byte_nxt = in_req.byte_value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= 1'b0;
    end else if (ctrl.load) begin
      init_r <= (in_req.cmd == lcdseq_pkg::OP_POWER_UP);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      byte_r <= byte_nxt;
      rs_r   <= rs_nxt;
    end
  end

  assign status.is_init = init_r;

  // The power-up settle saturates at the top of the 16-bit range.
  assign init_sum  = {1'b0, command_settle_r} + {1'b0, init_settle_r};
  assign init_hold = init_sum[16] ? 16'hFFFF : init_sum[15:0];
  assign cur_byte  = init_r ? lcdseq_pkg::init_byte(ctrl.byte_idx) : byte_r;

  always_comb begin
    if (rs_r) begin
      settle = data_settle_r;
    end else if (init_r && ctrl.last_byte) begin
      settle = init_hold;
    end else begin
      settle = command_settle_r;
    end
  end

  always_comb begin
    out_nxt.register_select = rs_r;
    out_nxt.read_write      = 1'b0;
    out_nxt.enable_pin      = (ctrl.phase == 3'd1) || (ctrl.phase == 3'd4);
    out_nxt.data_nibble     = (ctrl.phase < 3'd3) ? cur_byte[7:4] : cur_byte[3:0];
    out_nxt.last            = (ctrl.phase == lcdseq_pkg::PHASE_LAST) && ctrl.last_byte;
    if (out_nxt.enable_pin) begin
      out_nxt.hold_us = enable_pulse_r;
    end else if (ctrl.phase == lcdseq_pkg::PHASE_LAST) begin
      out_nxt.hold_us = settle;
    end else begin
      out_nxt.hold_us = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctrl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

// File: rtl/core/char_lcd_nibble_write_sequencer_top.sv
// Top level of the character LCD nibble write sequencer for a 4-bit HD44780 bus.
//
//   channel  | ports                               | handshake
//   ---------+-------------------------------------+---------------------------
//   input    | start, busy, in_req                 | taken when start && !busy
//   result   | out_valid, out_res                  | one-cycle strobe, no stall
//   config   | cfg_valid, cfg_ready, cfg_index,    | taken when valid && ready
//            | cfg_data                            |
//
// Each request yields one bus state per cycle: six for a command, a character
// or a cursor set, and 42 for power-up, paced by the phase and byte counters of
// the controller. A taken request reaches the output through the controller
// state register and then the datapath output register; the next request can
// be taken in the cycle that produces the final bus state, so back-to-back
// requests run with no gap. Reset is synchronous and active low; it returns the
// configuration registers to their default timings and idles the controller.
// The receiver cannot stall, so every bus state is shown for exactly one cycle.
module char_lcd_nibble_write_sequencer_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  lcdseq_pkg::in_item_t  in_req,
  output logic                  out_valid,
  output lcdseq_pkg::out_item_t out_res,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data
);

  // Command and status signals between the controller and the datapath.
  lcdseq_pkg::ctrl_cmd_t  ctrl;
  lcdseq_pkg::dp_status_t status;

  // The controller counts phases within a byte and bytes within a request.
  lcdseq_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .ctrl   (ctrl)
  );

  // The datapath holds the timings, the latched request and the output register.
  lcdseq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_req    (in_req),
    .ctrl      (ctrl),
    .status    (status),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

// File: rtl/core/lcdseq_chk.sv
// Port-level checker for the sequencer and its bind to the top level.
module lcdseq_chk (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_valid,
  input lcdseq_pkg::out_item_t out_res
);

  // The bus is only ever written.
  a_write_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res.read_write == 1'b0))
    else $error("read_write asserted on a bus state");

  // A taken request is followed by its first bus state.
  a_first_state: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("no bus state after a taken request");

  // Every EN pulse is followed by EN low with the nibble unchanged.
  a_en_fall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.enable_pin) |=>
      (out_valid && !out_res.enable_pin && $stable(out_res.data_nibble)))
    else $error("EN pulse not followed by a falling edge");

  // The final bus state of a request leaves EN low.
  a_last_en_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.last) |-> !out_res.enable_pin)
    else $error("final bus state with EN high");

endmodule

bind char_lcd_nibble_write_sequencer_top lcdseq_chk u_lcdseq_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_res   (out_res)
);

// File: tb/char_lcd_bus_state_checker.sv
// Bus-state predictor and scoreboard for the character LCD nibble write sequencer.
module char_lcd_bus_state_checker
  import lcdseq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_req,
  input  logic      out_valid,
  input  out_item_t out_res,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int        mismatches,
  output int        outstanding
);

  localparam int POWER_UP_LEN = 7;
  localparam int REPORT_LIMIT = 10;
  localparam logic [7:0] POWER_UP_SEQ [POWER_UP_LEN] =
    '{8'h33, 8'h32, 8'h28, 8'h01, 8'h02, 8'h06, 8'h0C};

  // Shadow copy of the timing registers.
  logic [15:0] pulse_us;
  logic [15:0] cmd_settle_us;
  logic [15:0] char_settle_us;
  logic [15:0] init_extra_us;

  out_item_t bus_state_q[$];

  // Six bus states per byte: high nibble set up, EN high, EN low, then the same for the low nibble.
  function automatic void queue_byte(input logic rs, input logic [7:0] value,
                                     input logic [15:0] settle, input logic fin);
    out_item_t s;
    for (int k = 0; k < 6; k++) begin
      s.register_select = rs;
      s.read_write      = 1'b0;
      s.enable_pin      = (k % 3 == 1);
      s.data_nibble     = (k < 3) ? value[7:4] : value[3:0];
      s.hold_us         = (k % 3 == 1) ? pulse_us : ((k == 5) ? settle : 16'd0);
      s.last            = (k == 5) ? fin : 1'b0;
      bus_state_q.push_back(s);
    end
  endfunction

  function automatic void predict_bus_states(input in_item_t r);
    logic [16:0] sum;
    logic [15:0] final_settle;
    logic [7:0]  addr;
    case (r.cmd)
      OP_WRITE_CMD:  queue_byte(1'b0, r.byte_value, cmd_settle_us, 1'b1);
      OP_WRITE_CHAR: queue_byte(1'b1, r.byte_value, char_settle_us, 1'b1);
      OP_SET_CURSOR: begin
        addr = (r.row ? ROW1_BASE : ROW0_BASE) + {2'b00, r.column};
        queue_byte(1'b0, addr, cmd_settle_us, 1'b1);
      end
      OP_POWER_UP: begin
        // The final settle of the sequence saturates rather than wrapping.
        sum = {1'b0, cmd_settle_us} + {1'b0, init_extra_us};
        final_settle = sum[16] ? 16'hFFFF : sum[15:0];
        for (int i = 0; i < POWER_UP_LEN - 1; i++)
          queue_byte(1'b0, POWER_UP_SEQ[i], cmd_settle_us, 1'b0);
        queue_byte(1'b0, POWER_UP_SEQ[POWER_UP_LEN-1], final_settle, 1'b1);
      end
    endcase
  endfunction

  function automatic void note_error(input string what, input out_item_t want,
                                     input out_item_t got, input bit has_want);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      if (has_want)
        $display("[%0t] %s: expected rs=%0d rw=%0d en=%0d nib=%h hold=%0d last=%0d",
                 $realtime, what, want.register_select, want.read_write,
                 want.enable_pin, want.data_nibble, want.hold_us, want.last);
      $display("[%0t] %s: actual   rs=%0d rw=%0d en=%0d nib=%h hold=%0d last=%0d",
               $realtime, what, got.register_select, got.read_write,
               got.enable_pin, got.data_nibble, got.hold_us, got.last);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      pulse_us       = RST_ENABLE_PULSE;
      cmd_settle_us  = RST_COMMAND_SETTLE;
      char_settle_us = RST_DATA_SETTLE;
      init_extra_us  = RST_INIT_SETTLE;
      mismatches     = 0;
      bus_state_q.delete();
    end else begin
      if (out_valid) begin
        if (bus_state_q.size() == 0) begin
          note_error("bus state with nothing expected", out_res, out_res, 1'b0);
        end else begin
          want = bus_state_q.pop_front();
          if (want.register_select !== out_res.register_select ||
              want.read_write      !== out_res.read_write      ||
              want.enable_pin      !== out_res.enable_pin      ||
              want.data_nibble     !== out_res.data_nibble     ||
              want.hold_us         !== out_res.hold_us         ||
              want.last            !== out_res.last)
            note_error("bus state mismatch", want, out_res, 1'b1);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ENABLE_PULSE:   pulse_us       = cfg_data;
          REG_COMMAND_SETTLE: cmd_settle_us  = cfg_data;
          REG_DATA_SETTLE:    char_settle_us = cfg_data;
          REG_INIT_SETTLE:    init_extra_us  = cfg_data;
        endcase
      end
      if (start && !busy)
        predict_bus_states(in_req);
    end
    outstanding = bus_state_q.size();
  end

endmodule

// File: tb/char_lcd_nibble_write_sequencer_top_test.sv
// Stimulus and verdict for the character LCD nibble write sequencer.
module char_lcd_nibble_write_sequencer_top_test;
  import lcdseq_pkg::*;

  // Clock period is 12 units; the reset is held low at start and released on a falling edge.
  localparam int HALF_PERIOD    = 6;
  localparam int PHASES         = 8;
  localparam int RANDOM_PER_PH  = 44;
  localparam int MAX_GAP        = 11;
  // A short pause after the last expected bus state is ample for the
  // block to fall idle.
  localparam int SETTLE_CYCLES  = 8;
  // The longest correct stretch without any handshake is a sender gap plus
  // the idle pause around a configuration write.
  localparam int WATCHDOG_LIMIT = 1000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_req;
  logic        out_valid;
  out_item_t   out_res;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  int mismatches;
  int outstanding;
  int idle_cycles;
  bit no_gaps;

  char_lcd_nibble_write_sequencer_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // The checker sees exactly what the block sees and predicts every bus state.
  char_lcd_bus_state_checker u_bus_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req      (in_req),
    .out_valid   (out_valid),
    .out_res     (out_res),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #HALF_PERIOD clk = ~clk;

  // The watchdog restarts whenever any channel completes a handshake; a block
  // that hangs, or stops producing bus states, trips it.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_item_t make_request(input logic [1:0] op, input logic [7:0] value,
                                            input logic line, input logic [5:0] col);
    in_item_t r;
    r.cmd        = op;
    r.byte_value = value;
    r.row        = line;
    r.column     = col;
    return r;
  endfunction

  // Every field is drawn over its whole width, so columns past the end of
  // the line and the ignored fields of each operation are exercised too.
  function automatic in_item_t random_request();
    return make_request(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
                        6'($urandom));
  endfunction

  // Inputs only ever change on the falling edge. A request that follows with
  // no gap keeps start high and simply swaps the payload, so start is never
  // dropped and raised in the same time step.
  task automatic send_request(input in_item_t r);
    int  gap;
    bit  taken;
    gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req = r;
    start  = 1'b1;
    taken  = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
      @(negedge clk);
    end
  endtask

  // Holds the sender off until every predicted bus state has been seen, and
  // then a little longer so that the block is truly idle.
  task automatic wait_bus_idle();
    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    bit taken;
    cfg_index = idx;
    cfg_data  = value;
    cfg_valid = 1'b1;
    taken     = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = cfg_ready;
      @(negedge clk);
    end
    cfg_valid = 1'b0;
  endtask

  task automatic program_timings(input logic [15:0] pulse, input logic [15:0] cmd_settle,
                                 input logic [15:0] char_settle, input logic [15:0] init_extra);
    write_reg(REG_ENABLE_PULSE, pulse);
    write_reg(REG_COMMAND_SETTLE, cmd_settle);
    write_reg(REG_DATA_SETTLE, char_settle);
    write_reg(REG_INIT_SETTLE, init_extra);
  endtask

  initial begin
    in_item_t directed[$];

    clk         = 1'b0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_req      = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_ENABLE_PULSE;
    cfg_data    = '0;
    no_gaps     = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed requests under the reset timings: byte extremes for commands
    // and characters, both cursor lines at the first column, the last real
    // column and the columns past the end of the line, and a power-up with
    // its ignored fields set.
    directed.push_back(make_request(OP_WRITE_CMD,  8'h00, 1'b0, 6'd0));
    directed.push_back(make_request(OP_WRITE_CMD,  8'hFF, 1'b1, 6'd63));
    directed.push_back(make_request(OP_WRITE_CMD,  8'hA5, 1'b0, 6'd21));
    directed.push_back(make_request(OP_WRITE_CHAR, 8'h00, 1'b1, 6'd63));
    directed.push_back(make_request(OP_WRITE_CHAR, 8'hFF, 1'b0, 6'd0));
    directed.push_back(make_request(OP_WRITE_CHAR, 8'h5A, 1'b1, 6'd42));
    directed.push_back(make_request(OP_SET_CURSOR, 8'h00, 1'b0, 6'd0));
    directed.push_back(make_request(OP_SET_CURSOR, 8'hFF, 1'b0, 6'd39));
    directed.push_back(make_request(OP_SET_CURSOR, 8'h00, 1'b0, 6'd63));
    directed.push_back(make_request(OP_SET_CURSOR, 8'hFF, 1'b1, 6'd0));
    directed.push_back(make_request(OP_SET_CURSOR, 8'h00, 1'b1, 6'd39));
    directed.push_back(make_request(OP_SET_CURSOR, 8'hFF, 1'b1, 6'd40));
    directed.push_back(make_request(OP_SET_CURSOR, 8'h3C, 1'b1, 6'd63));
    directed.push_back(make_request(OP_POWER_UP,   8'hFF, 1'b1, 6'd63));
    directed.push_back(make_request(OP_POWER_UP,   8'h00, 1'b0, 6'd0));
    directed.push_back(make_request(OP_WRITE_CHAR, 8'h41, 1'b0, 6'd0));
    foreach (directed[i]) send_request(directed[i]);
    wait_bus_idle();

    // Each phase but the first reprograms every register and then runs random requests.
    // The first few phases pin the timings to their extremes, including the
    // power-up settle landing exactly on, and just past, the saturation point.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: ;
        1: program_timings(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        2: program_timings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: program_timings(16'h0001, 16'h8000, 16'hFFFE, 16'h7FFF);
        4: program_timings(16'($urandom), 16'h8000, 16'($urandom), 16'h8000);
        default: program_timings(16'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom));
      endcase

      // Some phases run back to back with no sender gaps at all.
      no_gaps = (ph == 3) || ($urandom_range(0, 3) == 0);
      for (int n = 0; n < RANDOM_PER_PH; n++) begin
        // Halfway through, the sender pauses until the block has drained.
        if (n == RANDOM_PER_PH / 2) wait_bus_idle();
        send_request(random_request());
      end
      wait_bus_idle();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
